FILE: rtl/cdo_pkg.sv
package cdo_pkg;

    localparam int D2D_LAT = 3;
    localparam int C2D_LAT = 9;
    localparam int TOTAL_LAT = D2D_LAT + 1 + C2D_LAT + 1;

    localparam logic [15:0] CD_LIMIT_RST = 16'd99;
    localparam logic [15:0] URG_LIMIT_RST = 16'd7;

    localparam logic ADDR_CD_LIMIT = 1'b0;
    localparam logic ADDR_URG_LIMIT = 1'b1;

    localparam logic REQ_DIFF   = 1'b0;
    localparam logic REQ_OFFSET = 1'b1;

    localparam logic [17:0] DAYS_ERA = 18'd146097;

    // day of the march-based year on which a calendar month starts
    function automatic logic [8:0] month_base(input logic [3:0] mon);
        logic [8:0] v;
        begin
            case (mon)
                4'd0:    v = 9'd275;
                4'd1:    v = 9'd306;
                4'd2:    v = 9'd337;
                4'd3:    v = 9'd0;
                4'd4:    v = 9'd31;
                4'd5:    v = 9'd61;
                4'd6:    v = 9'd92;
                4'd7:    v = 9'd122;
                4'd8:    v = 9'd153;
                4'd9:    v = 9'd184;
                4'd10:   v = 9'd214;
                4'd11:   v = 9'd245;
                4'd12:   v = 9'd275;
                4'd13:   v = 9'd306;
                4'd14:   v = 9'd337;
                default: v = 9'd367;
            endcase
            return v;
        end
    endfunction

    // first day of march-based month index mp
    function automatic logic [8:0] mp_start(input logic [3:0] mp);
        logic [8:0] v;
        begin
            case (mp)
                4'd0:    v = 9'd0;
                4'd1:    v = 9'd31;
                4'd2:    v = 9'd61;
                4'd3:    v = 9'd92;
                4'd4:    v = 9'd122;
                4'd5:    v = 9'd153;
                4'd6:    v = 9'd184;
                4'd7:    v = 9'd214;
                4'd8:    v = 9'd245;
                4'd9:    v = 9'd275;
                4'd10:   v = 9'd306;
                default: v = 9'd337;
            endcase
            return v;
        end
    endfunction

    function automatic logic [1:0] cent_cnt(input logic [8:0] yoe);
        return 2'((yoe >= 9'd100) ? 1 : 0) + 2'((yoe >= 9'd200) ? 1 : 0)
             + 2'((yoe >= 9'd300) ? 1 : 0);
    endfunction

    typedef struct packed {
        logic               mode;
        logic signed [22:0] diff;
        logic [15:0]        cd;
        logic               urg;
    } t_side;

endpackage

FILE: rtl/cdo_d2d.sv
module cdo_d2d
    import cdo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [13:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    output logic               o_valid,
    output logic signed [23:0] o_days
);

    logic [D2D_LAT-1:0] r_vld;

    // stage 1
    logic signed [14:0] n_ya;
    logic [15:0]        n_p;
    logic [13:0]        r_ya;
    logic               r_neg;
    logic [5:0]         r_q0;
    logic signed [9:0]  r_doy1;

    assign n_ya = signed'({1'b0, i_year}) - signed'(15'((i_month <= 4'd2) ? 1 : 0));
    assign n_p  = {6'b0, n_ya[13:4]} * 16'd40;

    // day zero of march gives a day of year of minus one
    always_ff @(posedge i_clk) begin
        r_ya   <= n_ya[13:0];
        r_neg  <= n_ya[14];
        r_q0   <= n_p[15:10];
        r_doy1 <= signed'({1'b0, month_base(i_month)}) + signed'({5'b0, i_day}) - 10'sd1;
    end

    // stage 2
    logic [14:0]       n_r;
    logic              n_ge;
    logic signed [6:0] r_era;
    logic [8:0]        r_yoe;
    logic signed [9:0] r_doy2;

    assign n_r  = {1'b0, r_ya} - ({9'b0, r_q0} * 15'd400);
    assign n_ge = (n_r >= 15'd400);

    always_ff @(posedge i_clk) begin
        if (r_neg) begin
            r_era <= -7'sd1;
            r_yoe <= 9'd399;
        end else begin
            r_era <= signed'({1'b0, r_q0} + 7'(n_ge));
            r_yoe <= n_ge ? 9'(n_r - 15'd400) : n_r[8:0];
        end
        r_doy2 <= r_doy1;
    end

    // stage 3
    logic [18:0]        n_doe;
    logic signed [23:0] n_ep;
    logic signed [23:0] r_days;

    assign n_doe = ({10'b0, r_yoe} * 19'd365) + 19'(r_yoe >> 2)
                 - 19'(cent_cnt(r_yoe)) + 19'(r_doy2);
    assign n_ep  = 24'(r_era) * signed'({6'b0, DAYS_ERA});

    always_ff @(posedge i_clk) begin
        r_days <= n_ep + 24'(signed'(n_doe));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[D2D_LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[D2D_LAT-1];
    assign o_days  = r_days;

endmodule

FILE: rtl/cdo_c2d.sv
module cdo_c2d
    import cdo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [24:0] i_days,
    output logic               o_valid,
    output logic [13:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day,
    output logic               o_oor
);

    logic [C2D_LAT-1:0] r_vld;

    // stage 1: shift into one era up, then estimate era
    logic signed [24:0] n_zs;
    logic [22:0]        n_p1;
    logic [23:0]        r_zp;
    logic [6:0]         r_q0;

    assign n_zs = i_days + signed'({7'b0, DAYS_ERA});
    assign n_p1 = {9'b0, n_zs[23:10]} * 23'd459;

    always_ff @(posedge i_clk) begin
        r_zp <= n_zs[23:0];
        r_q0 <= n_p1[22:16];
    end

    // stage 2: correct era estimate
    logic [23:0]       n_r2;
    logic              n_ge2;
    logic [17:0]       r_doe2;
    logic signed [6:0] r_era2;

    assign n_r2  = r_zp - ({17'b0, r_q0} * 24'd146097);
    assign n_ge2 = (n_r2 >= 24'd146097);

    always_ff @(posedge i_clk) begin
        r_doe2 <= n_ge2 ? 18'(n_r2 - 24'd146097) : n_r2[17:0];
        r_era2 <= signed'(r_q0 + 7'(n_ge2) - 7'd1);
    end

    // stage 3
    logic [26:0]       n_p3;
    logic [17:0]       r_doe3;
    logic signed [6:0] r_era3;
    logic [6:0]        r_a0;
    logic [2:0]        r_c36;
    logic              r_e;

    assign n_p3 = {9'b0, r_doe2} * 27'd718;

    always_ff @(posedge i_clk) begin
        r_doe3 <= r_doe2;
        r_era3 <= r_era2;
        r_a0   <= n_p3[26:20];
        r_c36  <= 3'((r_doe2 >= 18'd36524) ? 1 : 0) + 3'((r_doe2 >= 18'd73048) ? 1 : 0)
                + 3'((r_doe2 >= 18'd109572) ? 1 : 0) + 3'((r_doe2 >= 18'd146096) ? 1 : 0);
        r_e    <= (r_doe2 == 18'd146096);
    end

    // stage 4
    logic [17:0]       n_r4;
    logic [6:0]        n_a;
    logic [17:0]       r_t;
    logic [17:0]       r_doe4;
    logic signed [6:0] r_era4;

    assign n_r4 = r_doe3 - ({11'b0, r_a0} * 18'd1460);
    assign n_a  = r_a0 + 7'((n_r4 >= 18'd1460) ? 1 : 0);

    always_ff @(posedge i_clk) begin
        r_t    <= r_doe3 - {11'b0, n_a} + {15'b0, r_c36} - {17'b0, r_e};
        r_doe4 <= r_doe3;
        r_era4 <= r_era3;
    end

    // stage 5: year of era estimate
    logic [28:0]       n_p5;
    logic [8:0]        r_yq0;
    logic [17:0]       r_t5;
    logic [17:0]       r_doe5;
    logic signed [6:0] r_era5;

    assign n_p5 = {11'b0, r_t} * 29'd2872;

    always_ff @(posedge i_clk) begin
        r_yq0  <= n_p5[28:20];
        r_t5   <= r_t;
        r_doe5 <= r_doe4;
        r_era5 <= r_era4;
    end

    // stage 6
    logic [17:0]       n_r6;
    logic [8:0]        r_yoe6;
    logic [17:0]       r_doe6;
    logic signed [6:0] r_era6;

    assign n_r6 = r_t5 - ({9'b0, r_yq0} * 18'd365);

    always_ff @(posedge i_clk) begin
        r_yoe6 <= r_yq0 + 9'((n_r6 >= 18'd365) ? 1 : 0);
        r_doe6 <= r_doe5;
        r_era6 <= r_era5;
    end

    // stage 7: day of march-based year
    logic [17:0]       n_doy7;
    logic [8:0]        r_doy7;
    logic [8:0]        r_yoe7;
    logic signed [6:0] r_era7;

    assign n_doy7 = r_doe6 - (({9'b0, r_yoe6} * 18'd365) + 18'(r_yoe6 >> 2)
                  - 18'(cent_cnt(r_yoe6)));

    always_ff @(posedge i_clk) begin
        r_doy7 <= n_doy7[8:0];
        r_yoe7 <= r_yoe6;
        r_era7 <= r_era6;
    end

    // stage 8: month index
    logic [10:0]       n_v;
    logic [17:0]       n_p8;
    logic [3:0]        n_mq0;
    logic [10:0]       n_r8;
    logic [3:0]        r_mp;
    logic [8:0]        r_doy8;
    logic [8:0]        r_yoe8;
    logic signed [6:0] r_era8;

    assign n_v   = ({2'b0, r_doy7} * 11'd5) + 11'd2;
    assign n_p8  = {7'b0, n_v} * 18'd107;
    assign n_mq0 = n_p8[17:14];
    assign n_r8  = n_v - ({7'b0, n_mq0} * 11'd153);

    always_ff @(posedge i_clk) begin
        r_mp   <= n_mq0 + 4'((n_r8 >= 11'd153) ? 1 : 0);
        r_doy8 <= r_doy7;
        r_yoe8 <= r_yoe7;
        r_era8 <= r_era7;
    end

    // stage 9: calendar fields and range check
    logic signed [15:0] n_y;
    logic               n_oor;
    logic [8:0]         n_d;
    logic [13:0]        r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;
    logic               r_oor;

    assign n_y   = (16'(r_era8) * 16'sd400) + signed'({7'b0, r_yoe8})
                 + signed'(16'((r_mp >= 4'd10) ? 1 : 0));
    assign n_oor = (n_y < 16'sd0) || (n_y > 16'sd9999);
    assign n_d   = r_doy8 - mp_start(r_mp) + 9'd1;

    always_ff @(posedge i_clk) begin
        r_oor <= n_oor;
        if (n_oor) begin
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
        end else begin
            r_year  <= n_y[13:0];
            r_month <= (r_mp < 4'd10) ? (r_mp + 4'd3) : (r_mp - 4'd9);
            r_day   <= n_d[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[C2D_LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[C2D_LAT-1];
    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;
    assign o_oor   = r_oor;

endmodule

FILE: rtl/civil_date_difference_and_offset_top.sv
// proleptic gregorian date unit: day difference between two dates, or a date
// plus a signed day offset.
// requests: a transfer happens at each rising edge with start high and busy
// low; busy is never raised, so a new request may come every cycle.
// results: o_valid marks one cycle holding a single result; the receiver
// takes it at the end of that cycle and cannot stall the unit.
// throughput is one request per cycle, set by a fully pipelined datapath:
// three stages turn each date into a day number, one stage forms the
// difference or the offset date, nine stages turn a day number back into
// a calendar date, and one output register.
// apb port: countdown_limit at 0x0, urgent_limit at 0x4, zero wait states;
// write limits only while no request is in flight.
// reset clears all valid bits and puts the limits back to 99 and 7; requests
// in flight are dropped.
module civil_date_difference_and_offset_top
    import cdo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [13:0]        i_base_year,
    input  logic [3:0]         i_base_month,
    input  logic [4:0]         i_base_day,
    input  logic [13:0]        i_other_year,
    input  logic [3:0]         i_other_month,
    input  logic [4:0]         i_other_day,
    input  logic signed [16:0] i_day_offset,
    output logic               o_valid,
    output logic signed [22:0] o_day_difference,
    output logic [15:0]        o_countdown,
    output logic               o_urgent,
    output logic [13:0]        o_result_year,
    output logic [3:0]         o_result_month,
    output logic [4:0]         o_result_day,
    output logic               o_out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] r_cd_limit;
    logic [15:0] r_urg_limit;
    logic        acc;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign acc    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_limit  <= CD_LIMIT_RST;
            r_urg_limit <= URG_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                ADDR_CD_LIMIT:  r_cd_limit  <= pwdata[15:0];
                ADDR_URG_LIMIT: r_urg_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == ADDR_URG_LIMIT) ? {16'b0, r_urg_limit}
                                                 : {16'b0, r_cd_limit};

    // both dates to day numbers
    logic               base_vld;
    logic               other_vld;
    logic signed [23:0] base_days;
    logic signed [23:0] other_days;

    cdo_d2d u_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_year  (i_base_year),
        .i_month (i_base_month),
        .i_day   (i_base_day),
        .o_valid (base_vld),
        .o_days  (base_days)
    );

    cdo_d2d u_other (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_year  (i_other_year),
        .i_month (i_other_month),
        .i_day   (i_other_day),
        .o_valid (other_vld),
        .o_days  (other_days)
    );

    // request mode and offset ride alongside the conversion
    logic               r_mode_dl [D2D_LAT];
    logic signed [16:0] r_off_dl  [D2D_LAT];

    always_ff @(posedge i_clk) begin
        r_mode_dl[0] <= i_req_type;
        r_off_dl[0]  <= i_day_offset;
        for (int k = 1; k < D2D_LAT; k++) begin
            r_mode_dl[k] <= r_mode_dl[k-1];
            r_off_dl[k]  <= r_off_dl[k-1];
        end
    end

    // difference and offset date number
    logic signed [24:0] n_diff;
    logic               n_cd_ok;
    t_side              n_side;
    logic signed [24:0] r_z;
    logic               r_t_vld;

    assign n_diff  = 25'(other_days) - 25'(base_days);
    assign n_cd_ok = (n_diff >= 25'sd1) && (n_diff <= signed'({9'b0, r_cd_limit}));

    always_comb begin
        n_side      = '0;
        n_side.mode = r_mode_dl[D2D_LAT-1];
        if (r_mode_dl[D2D_LAT-1] == REQ_DIFF) begin
            if (n_diff > 25'sd4194303) begin
                n_side.diff = 23'sd4194303;
            end else if (n_diff < -25'sd4194304) begin
                n_side.diff = -23'sd4194304;
            end else begin
                n_side.diff = n_diff[22:0];
            end
            n_side.cd  = n_cd_ok ? n_diff[15:0] : 16'd0;
            n_side.urg = n_cd_ok && (n_diff <= signed'({9'b0, r_urg_limit}));
        end
    end

    t_side r_side [C2D_LAT+1];

    always_ff @(posedge i_clk) begin
        r_z       <= 25'(base_days) + 25'(r_off_dl[D2D_LAT-1]);
        r_side[0] <= n_side;
        for (int k = 1; k <= C2D_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else begin
            r_t_vld <= base_vld && other_vld;
        end
    end

    // day number back to a date
    logic        c_vld;
    logic [13:0] c_year;
    logic [3:0]  c_month;
    logic [4:0]  c_day;
    logic        c_oor;

    cdo_c2d u_c2d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t_vld),
        .i_days  (r_z),
        .o_valid (c_vld),
        .o_year  (c_year),
        .o_month (c_month),
        .o_day   (c_day),
        .o_oor   (c_oor)
    );

    // output register
    t_side       side_o;
    logic        r_o_vld;
    logic [22:0] r_diff;
    logic [15:0] r_cd;
    logic        r_urg;
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic        r_oor;

    assign side_o = r_side[C2D_LAT];

    always_ff @(posedge i_clk) begin
        r_diff <= side_o.diff;
        r_cd   <= side_o.cd;
        r_urg  <= side_o.urg;
        if (side_o.mode == REQ_OFFSET) begin
            r_year  <= c_year;
            r_month <= c_month;
            r_day   <= c_day;
            r_oor   <= c_oor;
        end else begin
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_oor   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= c_vld;
        end
    end

    assign o_valid          = r_o_vld;
    assign o_day_difference = signed'(r_diff);
    assign o_countdown      = r_cd;
    assign o_urgent         = r_urg;
    assign o_result_year    = r_year;
    assign o_result_month   = r_month;
    assign o_result_day     = r_day;
    assign o_out_of_range   = r_oor;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##(TOTAL_LAT) o_valid)
        else $error("result missing after a request transfer");

    a_urgent_cd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_urgent) |-> (o_countdown != 16'd0 && o_countdown <= r_urg_limit))
        else $error("urgent without a countdown inside the urgent limit");

    a_cd_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_countdown <= r_cd_limit))
        else $error("countdown above its limit");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_result_year == 14'd0 && o_result_month == 4'd0
                                         && o_result_day == 5'd0))
        else $error("out of range result carries a date");

endmodule
